// ----- sv/gvn_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid vertex normal engine package
// Shared payload types, controller commands and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package gvn_pkg;

  localparam int GVN_DEPTH = 4096;
  localparam int GVN_AW    = 12;
  localparam int GVN_TW    = 14;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_NORMAL = 1'b1;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } gvn_in_t;

  typedef struct packed {
    logic [11:0]        result_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } gvn_out_t;

  typedef struct packed {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic signed [24:0] z;
  } gvn_diff_t;

  typedef struct packed {
    logic       wr;
    logic       start;
    logic       mod_step;
    logic       nbr_a;
    logic       nbr_b;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_c;
    logic       cap_n;
    logic       mul_en;
    logic [2:0] psel;
    logic       rot;
    logic       norm_init;
    logic       norm_step;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       out_ld;
  } gvn_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic zero;
  } gvn_status_t;

endpackage

`default_nettype wire

// ----- sv/gvn_dpath.sv -----
// ----------------------------------------------------------------------------
// Grid vertex normal datapath
// Position store, index arithmetic, shared multiplier, bit-serial root and
// divide, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gvn_dpath import gvn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gvn_cmd_t          cmd_i,
  input  gvn_in_t           in_data_i,
  input  logic [6:0]        cols_i,
  input  logic [GVN_TW-1:0] total_i,
  output gvn_status_t       status_o,
  output gvn_out_t          out_data_o
);

  logic [71:0]        mem_q [GVN_DEPTH];
  logic [71:0]        rdata_q;
  logic [GVN_AW-1:0]  vidx_q, idx_sh_q, rd_addr;
  logic [GVN_TW-1:0]  rem_q, cols_ext;
  logic [GVN_TW:0]    rem_sh, b_sum;
  logic [GVN_TW-1:0]  l_q, r_q, t_q, b_q, tr_q, bl_q;
  logic [GVN_TW-1:0]  l_d, r_d, t_d, b_d, tr_d, bl_d;
  logic [GVN_TW:0]    tr_sum;
  logic signed [23:0] cx_q, cy_q, cz_q;
  gvn_diff_t          ring_q [6];
  gvn_diff_t          new_diff, da, db;
  logic signed [30:0] op_a, op_b;
  logic signed [61:0] prod_q;
  logic               mul_vld_q, mul_sq_q;
  logic [2:0]         psel_q;
  logic signed [53:0] accx_q, accy_q, accz_q, term;
  logic [53:0]        m0_q, m1_q, m2_q, big;
  logic               n0_q, n1_q, n2_q;
  logic [61:0]        sq_acc_q;
  logic [62:0]        v_q, res_q, bit_q, trial;
  logic [31:0]        root, dvs;
  logic [46:0]        dsh_q, rm0_q, rm1_q, rm2_q;
  logic               ge0, ge1, ge2;
  logic [15:0]        q0_q, q1_q, q2_q;
  gvn_out_t           out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[in_data_i.vertex_index] <= {in_data_i.pos_x, in_data_i.pos_y, in_data_i.pos_z};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign cols_ext = GVN_TW'(cols_i);
  assign rem_sh   = {rem_q, idx_sh_q[GVN_AW-1]};
  assign b_sum    = {1'b0, rem_q} + {1'b0, cols_ext};
  assign tr_sum   = {1'b0, t_q} + (GVN_TW + 1)'(1);

  always_comb begin
    l_d  = (rem_q == '0) ? total_i - GVN_TW'(1) : rem_q - GVN_TW'(1);
    r_d  = (rem_q + GVN_TW'(1) == total_i) ? '0 : rem_q + GVN_TW'(1);
    t_d  = (rem_q >= cols_ext) ? rem_q - cols_ext : rem_q + total_i - cols_ext;
    b_d  = (b_sum >= {1'b0, total_i}) ? GVN_TW'(b_sum - {1'b0, total_i}) : b_sum[GVN_TW-1:0];
    tr_d = (tr_sum == {1'b0, total_i}) ? '0 : tr_sum[GVN_TW-1:0];
    bl_d = (b_q == '0) ? total_i - GVN_TW'(1) : b_q - GVN_TW'(1);
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      3'd1:    rd_addr = l_q[GVN_AW-1:0];
      3'd2:    rd_addr = t_q[GVN_AW-1:0];
      3'd3:    rd_addr = tr_q[GVN_AW-1:0];
      3'd4:    rd_addr = r_q[GVN_AW-1:0];
      3'd5:    rd_addr = b_q[GVN_AW-1:0];
      3'd6:    rd_addr = bl_q[GVN_AW-1:0];
      default: rd_addr = rem_q[GVN_AW-1:0];
    endcase
  end

  always_comb begin
    new_diff.x = 25'($signed(rdata_q[71:48])) - 25'(cx_q);
    new_diff.y = 25'($signed(rdata_q[47:24])) - 25'(cy_q);
    new_diff.z = 25'($signed(rdata_q[23:0])) - 25'(cz_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vidx_q   <= in_data_i.vertex_index;
      idx_sh_q <= in_data_i.vertex_index;
      rem_q    <= '0;
    end else if (cmd_i.mod_step) begin
      idx_sh_q <= {idx_sh_q[GVN_AW-2:0], 1'b0};
      rem_q    <= (rem_sh >= {1'b0, total_i}) ? GVN_TW'(rem_sh - {1'b0, total_i})
                                               : rem_sh[GVN_TW-1:0];
    end
    if (cmd_i.nbr_a) begin
      l_q <= l_d;
      r_q <= r_d;
      t_q <= t_d;
      b_q <= b_d;
    end
    if (cmd_i.nbr_b) begin
      tr_q <= tr_d;
      bl_q <= bl_d;
    end
    if (cmd_i.cap_c) begin
      cx_q <= $signed(rdata_q[71:48]);
      cy_q <= $signed(rdata_q[47:24]);
      cz_q <= $signed(rdata_q[23:0]);
    end
    if (cmd_i.cap_n || cmd_i.rot) begin
      for (int i = 0; i < 5; i++) begin
        ring_q[i] <= ring_q[i+1];
      end
      ring_q[5] <= cmd_i.cap_n ? new_diff : ring_q[0];
    end
  end

  assign da = ring_q[1];
  assign db = ring_q[0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (cmd_i.sq_en) begin
      op_b = '0;
      unique case (cmd_i.sq_sel)
        2'd0:    op_a = {1'b0, m0_q[29:0]};
        2'd1:    op_a = {1'b0, m1_q[29:0]};
        default: op_a = {1'b0, m2_q[29:0]};
      endcase
      op_b = op_a;
    end else begin
      unique case (cmd_i.psel)
        3'd0:    begin op_a = 31'(da.y); op_b = 31'(db.z); end
        3'd1:    begin op_a = 31'(da.z); op_b = 31'(db.y); end
        3'd2:    begin op_a = 31'(da.z); op_b = 31'(db.x); end
        3'd3:    begin op_a = 31'(da.x); op_b = 31'(db.z); end
        3'd4:    begin op_a = 31'(da.x); op_b = 31'(db.y); end
        3'd5:    begin op_a = 31'(da.y); op_b = 31'(db.x); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign term = psel_q[0] ? -$signed(prod_q[53:0]) : $signed(prod_q[53:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      mul_sq_q  <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.mul_en | cmd_i.sq_en;
      mul_sq_q  <= cmd_i.sq_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    psel_q <= cmd_i.psel;
    if (cmd_i.start) begin
      accx_q <= '0;
      accy_q <= '0;
      accz_q <= '0;
    end else if (mul_vld_q && !mul_sq_q) begin
      unique case (psel_q[2:1])
        2'd0:    accx_q <= accx_q + term;
        2'd1:    accy_q <= accy_q + term;
        default: accz_q <= accz_q + term;
      endcase
    end
    if (cmd_i.norm_init) begin
      sq_acc_q <= '0;
    end else if (mul_vld_q && mul_sq_q) begin
      sq_acc_q <= sq_acc_q + prod_q;
    end
  end

  always_comb begin
    big = m0_q;
    if (m1_q > big) big = m1_q;
    if (m2_q > big) big = m2_q;
  end

  assign status_o.zero      = (big == '0);
  assign status_o.norm_done = (big[53:30] == '0) && big[29];

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_init) begin
      n0_q <= accx_q[53];
      n1_q <= accy_q[53];
      n2_q <= accz_q[53];
      m0_q <= accx_q[53] ? 54'(-accx_q) : 54'(accx_q);
      m1_q <= accy_q[53] ? 54'(-accy_q) : 54'(accy_q);
      m2_q <= accz_q[53] ? 54'(-accz_q) : 54'(accz_q);
    end else if (cmd_i.norm_step) begin
      if (big[53:30] != '0) begin
        m0_q <= m0_q >> 1;
        m1_q <= m1_q >> 1;
        m2_q <= m2_q >> 1;
      end else begin
        m0_q <= m0_q << 1;
        m1_q <= m1_q << 1;
        m2_q <= m2_q << 1;
      end
    end
  end

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      v_q   <= {1'b0, sq_acc_q};
      res_q <= '0;
      bit_q <= {1'b1, 62'b0};
    end else if (cmd_i.sqrt_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root = res_q[31:0];
  assign dvs  = {root[30:0], 1'b0};
  assign ge0  = rm0_q >= dsh_q;
  assign ge1  = rm1_q >= dsh_q;
  assign ge2  = rm2_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dsh_q <= {dvs, 15'b0};
      rm0_q <= {2'b0, m0_q[29:0], 15'b0} + {15'b0, root};
      rm1_q <= {2'b0, m1_q[29:0], 15'b0} + {15'b0, root};
      rm2_q <= {2'b0, m2_q[29:0], 15'b0} + {15'b0, root};
      q0_q  <= '0;
      q1_q  <= '0;
      q2_q  <= '0;
    end else if (cmd_i.div_step) begin
      dsh_q <= dsh_q >> 1;
      rm0_q <= ge0 ? rm0_q - dsh_q : rm0_q;
      rm1_q <= ge1 ? rm1_q - dsh_q : rm1_q;
      rm2_q <= ge2 ? rm2_q - dsh_q : rm2_q;
      q0_q  <= {q0_q[14:0], ge0};
      q1_q  <= {q1_q[14:0], ge1};
      q2_q  <= {q2_q[14:0], ge2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.result_index <= vidx_q;
      if (status_o.zero) begin
        out_q.normal_x <= '0;
        out_q.normal_y <= '0;
        out_q.normal_z <= '0;
      end else begin
        out_q.normal_x <= n0_q ? -$signed(q0_q) : $signed(q0_q);
        out_q.normal_y <= n1_q ? -$signed(q1_q) : $signed(q1_q);
        out_q.normal_z <= n2_q ? -$signed(q2_q) : $signed(q2_q);
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- sv/gvn_ctrl.sv -----
// ----------------------------------------------------------------------------
// Grid vertex normal controller
// Sequences the phases of a normal query and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gvn_ctrl import gvn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_cmd_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  gvn_status_t status_i,
  output gvn_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MOD   = 10'b0000000010,
    S_NBR   = 10'b0000000100,
    S_LOAD  = 10'b0000001000,
    S_CROSS = 10'b0000010000,
    S_NORM  = 10'b0000100000,
    S_SQ    = 10'b0001000000,
    S_SQRT  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } gvn_state_e;

  gvn_state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] tri_q, tri_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    tri_d      = tri_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_STORE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == 6'd11) begin
          cnt_d   = '0;
          state_d = S_NBR;
        end
      end
      S_NBR: begin
        if (cnt_q == 6'd0) begin
          cmd_o.nbr_a = 1'b1;
          cnt_d       = 6'd1;
        end else begin
          cmd_o.nbr_b = 1'b1;
          cnt_d       = '0;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.rd_en  = (cnt_q < 6'd7);
        cmd_o.rd_sel = cnt_q[2:0];
        cmd_o.cap_c  = (cnt_q == 6'd1);
        cmd_o.cap_n  = (cnt_q >= 6'd2);
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd7) begin
          cnt_d   = '0;
          tri_d   = '0;
          state_d = S_CROSS;
        end
      end
      S_CROSS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.psel   = cnt_q[2:0];
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd5) begin
          cmd_o.rot = 1'b1;
          cnt_d     = '0;
          tri_d     = tri_q + 3'd1;
          if (tri_q == 3'd5) begin
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (cnt_q == 6'd0) begin
          cnt_d = 6'd1;
        end else if (cnt_q == 6'd1) begin
          cmd_o.norm_init = 1'b1;
          cnt_d           = 6'd2;
        end else if (status_i.zero) begin
          state_d = S_OUT;
        end else if (status_i.norm_done) begin
          cnt_d   = '0;
          state_d = S_SQ;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.sq_en  = (cnt_q < 6'd3);
        cmd_o.sq_sel = cnt_q[1:0];
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == 6'd0);
        cmd_o.sqrt_step = (cnt_q != 6'd0);
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_init = (cnt_q == 6'd0);
        cmd_o.div_step = (cnt_q != 6'd0);
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == 6'd16) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_ld | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tri_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tri_q       <= tri_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("Result register loaded while a transaction is pending.");

  a_shift_only_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.norm_step |-> (!status_i.zero && !status_i.norm_done))
    else $error("Normalizing shift issued on an aligned or zero sum.");

  a_square_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sq_en |-> status_i.norm_done)
    else $error("Square issued before magnitudes were aligned.");

  a_load_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_MOD && cnt_q == 6'd0))
    else $error("Query did not enter the index reduction phase.");

endmodule

`default_nettype wire

// ----- sv/grid_vertex_normal_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Grid vertex normal engine
// Stores grid vertex positions and returns the averaged unit normal of a
// vertex from its six surrounding triangles.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload        Direction
//  in       in_valid/in_stall   gvn_in_t       into block
//  out      out_valid/out_stall gvn_out_t      out of block
//  cfg      cfg_valid/cfg_ready index, 7 bits  into block
//
//  A normal query takes longer with each normalizing shift (up to 29); its
//  time is set by the shared 31x31 multiplier, the one-bit-per-step index
//  reduction, square root and divide.
//  The position store has no reset; grid_cols and grid_rows reset to 64.
//  A finished result waits in the output register while the next transaction
//  is accepted; a query stalls only when its result finds that register full.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_vertex_normal_engine_unit import gvn_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  gvn_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output gvn_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  logic [6:0]        cols_q, rows_q, cols_eff, rows_eff;
  logic [GVN_TW-1:0] total;
  gvn_cmd_t          cmd;
  gvn_status_t       status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_GRID_COLS) begin
        cols_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_GRID_ROWS) begin
        rows_q <= cfg_data_i;
      end
    end
  end

  assign cols_eff = (cols_q < 7'd2) ? 7'd2 :
                    ((32'(cols_q) > MAX_COLS) ? 7'(MAX_COLS) : cols_q);
  assign rows_eff = (rows_q < 7'd2) ? 7'd2 :
                    ((32'(rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_q);
  assign total    = GVN_TW'({7'b0, cols_eff} * {7'b0, rows_eff});

  gvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gvn_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cols_i     (cols_eff),
    .total_i    (total),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/grid_vertex_normal_engine_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Grid vertex normal engine testbench
// Drives store and normal-query transactions at random rates, predicts every
// normal from its own copy of the position store and compares the results in
// order.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_vertex_normal_engine_unit_tb;
  import gvn_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  gvn_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  gvn_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i = '0;

  grid_vertex_normal_engine_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [23:0] mem_x [GVN_DEPTH];
  logic signed [23:0] mem_y [GVN_DEPTH];
  logic signed [23:0] mem_z [GVN_DEPTH];
  bit                 written [GVN_DEPTH];
  int unsigned        cols_q = 64, rows_q = 64;
  gvn_out_t           normals_due [$];
  int                 errors = 0;
  int                 send_idle = 0, recv_idle = 0;
  bit                 hold_out = 1'b0;
  int                 quiet = 0;

  task automatic report(input string what, input gvn_out_t got, input gvn_out_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned eff_total(output int unsigned c);
    int unsigned r;
    c = cols_q < 2 ? 2 : (cols_q > 64 ? 64 : cols_q);
    r = rows_q < 2 ? 2 : (rows_q > 64 ? 64 : rows_q);
    return c * r;
  endfunction

  function automatic gvn_out_t vertex_normal(input logic [11:0] vi);
    int unsigned c, tot, idx[7];
    longint px[7], py[7], pz[7], s[3], ax, ay, az, bx, by, bz;
    longint unsigned m[3], big, sq, r, q;
    int rs, ls;
    int pa[6], pb[6];
    gvn_out_t o;
    tot = eff_total(c);
    idx[0] = vi % tot;
    idx[1] = (idx[0] + tot - 1) % tot;
    idx[2] = (idx[0] + 1) % tot;
    idx[3] = (idx[0] + tot - c) % tot;
    idx[4] = (idx[0] + c) % tot;
    idx[5] = (idx[3] + 1) % tot;
    idx[6] = (idx[4] + tot - 1) % tot;
    for (int i = 0; i < 7; i++) begin
      px[i] = mem_x[idx[i]]; py[i] = mem_y[idx[i]]; pz[i] = mem_z[idx[i]];
    end
    // Pairs (first, second): (l,t) (t,tr) (tr,r) (r,b) (b,bl) (bl,l).
    pa = '{1, 3, 5, 2, 4, 6};
    pb = '{3, 5, 2, 4, 6, 1};
    s = '{0, 0, 0};
    for (int k = 0; k < 6; k++) begin
      ax = px[pb[k]] - px[0]; ay = py[pb[k]] - py[0]; az = pz[pb[k]] - pz[0];
      bx = px[pa[k]] - px[0]; by = py[pa[k]] - py[0]; bz = pz[pa[k]] - pz[0];
      s[0] += ay * bz - az * by;
      s[1] += az * bx - ax * bz;
      s[2] += ax * by - ay * bx;
    end
    o.result_index = vi;
    for (int i = 0; i < 3; i++) m[i] = s[i] < 0 ? -s[i] : s[i];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    if (big == 0) begin
      o.normal_x = '0; o.normal_y = '0; o.normal_z = '0;
      return o;
    end
    rs = 0; ls = 0;
    while (big >= (64'd1 << 30)) begin big >>= 1; rs++; end
    while (big < (64'd1 << 29)) begin big <<= 1; ls++; end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sq += m[i] * m[i];
    end
    r = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      q = (2 * m[i] * 16384 + r) / (2 * r);
      m[i] = s[i] < 0 ? -q : q;
    end
    o.normal_x = m[0][15:0]; o.normal_y = m[1][15:0]; o.normal_z = m[2][15:0];
    return o;
  endfunction

  always @(posedge clk_i) begin
    gvn_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (normals_due.size() == 0) begin
        report("unexpected", out_data_o, '0);
      end else begin
        want = normals_due.pop_front();
        if (out_data_o.result_index !== want.result_index) report("index", out_data_o, want);
        if (out_data_o.normal_x !== want.normal_x) report("normal_x", out_data_o, want);
        if (out_data_o.normal_y !== want.normal_y) report("normal_y", out_data_o, want);
        if (out_data_o.normal_z !== want.normal_z) report("normal_z", out_data_o, want);
      end
    end
    out_stall_i <= hold_out || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet++;
    if (quiet > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Valid stays high after a transaction until the sender idles or drains.
  task automatic send_item(input logic cmd, input logic [11:0] vi,
                           input logic signed [23:0] x, y, z);
    gvn_in_t it;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    it.cmd = cmd; it.vertex_index = vi; it.pos_x = x; it.pos_y = y; it.pos_z = z;
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_STORE) begin
      mem_x[vi] = x; mem_y[vi] = y; mem_z[vi] = z; written[vi] = 1'b1;
    end else begin
      normals_due.push_back(vertex_normal(vi));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_GRID_COLS) cols_q = int'(val); else rows_q = int'(val);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(2000) - 1000);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic fill_grid();
    int unsigned c, tot;
    tot = eff_total(c);
    for (int i = 0; i < tot; i++)
      send_item(CMD_STORE, 12'(i), rand_coord(), rand_coord(), rand_coord());
  endtask

  function automatic logic [11:0] query_index();
    int unsigned c, tot, v;
    tot = eff_total(c);
    // Out-of-range indices are allowed as long as the reduced one was written.
    v = $urandom_range(4095);
    if ($urandom_range(3) == 0 && written[v % tot]) return 12'(v);
    return 12'($urandom_range(tot - 1));
  endfunction

  task automatic test_directed();
    write_reg(REG_GRID_COLS, 7'd2);
    write_reg(REG_GRID_ROWS, 7'd2);
    for (int i = 0; i < 4; i++) send_item(CMD_STORE, 12'(i), '0, '0, '0);
    send_item(CMD_NORMAL, 12'd0, '0, '0, '0);
    send_item(CMD_STORE, 12'd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_item(CMD_STORE, 12'd1, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send_item(CMD_STORE, 12'd2, 24'sh000001, 24'shFFFFFF, 24'sh800000);
    send_item(CMD_STORE, 12'd3, 24'sh400000, 24'sh123456, 24'shABCDEF);
    send_item(CMD_NORMAL, 12'd0, '0, '0, '0);
    send_item(CMD_NORMAL, 12'd3, '0, '0, '0);
    send_item(CMD_NORMAL, 12'hFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(CMD_STORE, 12'hFFF, 24'sh555555, 24'shAAAAAA, 24'sh000000);
    drain();
    write_reg(REG_GRID_COLS, 7'd0);
    write_reg(REG_GRID_ROWS, 7'd127);
    // The top neighbor of vertex 1 wraps to the last vertex of the grid.
    send_item(CMD_STORE, 12'd127, 24'sh012345, 24'shFEDCBA, 24'sh00F00F);
    send_item(CMD_NORMAL, 12'd1, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) send_item(CMD_STORE, query_index(),
                                             rand_coord(), rand_coord(), rand_coord());
      else send_item(CMD_NORMAL, query_index(), rand_coord(), rand_coord(), rand_coord());
      sent++;
    end
  endtask

  task automatic test_config(input logic [6:0] c, input logic [6:0] r, input int n);
    drain();
    write_reg(REG_GRID_COLS, c);
    write_reg(REG_GRID_ROWS, r);
    fill_grid();
    test_random(n);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_out = 1'b0;
      end
      test_random(20);
    join
    drain();
    test_random(10);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle = 18; recv_idle = 79;
    test_config(7'd3, 7'd2, 120);
    test_config(7'd5, 7'd7, 150);
    send_idle = 79; recv_idle = 18;
    test_config(7'd64, 7'd2, 100);
    test_config(7'd2, 7'd64, 100);
    send_idle = 0; recv_idle = 0;
    test_config(7'd4, 7'd3, 80);
    test_backpressure();
    test_config(7'd8, 7'd8, 150);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/gvn_pkg.sv
sv/gvn_dpath.sv
sv/gvn_ctrl.sv
sv/grid_vertex_normal_engine_unit.sv
tb/grid_vertex_normal_engine_unit_tb.sv
